// ===== rtl/fndp_pkg.sv =====
// Package with shared widths, the queue flag type and the E2M1 weight decoder.
`default_nettype none

package fndp_pkg;

    // Widths of the item fields and of the internal products.
    localparam int ITEM_W         = 64;
    localparam int ACT_W          = 8;
    localparam int CODE_W         = 4;
    localparam int MAG_W          = 4;
    localparam int PROD_W         = 12;
    localparam int OUT_W          = 32;
    localparam int LANES_PER_WORD = 8;

    // Status flags of the work queue between the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

    // Magnitude of an E2M1 code, scaled by two so that it is an integer.
    function automatic logic [MAG_W-1:0] e2m1_mag(input logic [CODE_W-2:0] code);
        logic [MAG_W-1:0] mag;
        case (code)
            3'd0: mag = 4'd0;
            3'd1: mag = 4'd1;
            3'd2: mag = 4'd2;
            3'd3: mag = 4'd3;
            3'd4: mag = 4'd4;
            3'd5: mag = 4'd6;
            3'd6: mag = 4'd8;
            3'd7: mag = 4'd12;
            default: mag = 4'd0;
        endcase
        return mag;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fndp_queue.sv =====
// Small first-in first-out work queue built from flip-flops.
`default_nettype none

module fndp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output fndp_pkg::t_q_flags    o_flags,
    output logic      [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_push;
    logic             w_do_pop;

    // A push is taken only when there is room, a pop only when a word waits.
    assign o_flags.full  = (r_count == CNT_W'(DEPTH));
    assign o_flags.empty = (r_count == '0);
    assign w_do_push     = i_push && !o_flags.full;
    assign w_do_pop      = i_pop && !o_flags.empty;
    assign o_data        = r_mem[r_rd_ptr];

    // Pointer and count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset; the count guards every read.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fndp_front.sv =====
// Front part: accepts words, decodes the weights and forms the lane products.
`default_nettype none

module fndp_front #(
    parameter int LANES = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_push,
    output logic                                       o_full,
    input  wire logic [fndp_pkg::ITEM_W-1:0]           i_acts_low,
    input  wire logic [fndp_pkg::ITEM_W-1:0]           i_acts_high,
    input  wire logic [fndp_pkg::ITEM_W-1:0]           i_weight_bytes,
    input  wire logic                                  i_last_item,
    output logic                                       o_q_push,
    input  wire fndp_pkg::t_q_flags                    i_q_flags,
    output logic [LANES*fndp_pkg::PROD_W:0]            o_q_data
);

    localparam int PROD_W = fndp_pkg::PROD_W;
    localparam int ACT_W  = fndp_pkg::ACT_W;
    localparam int CODE_W = fndp_pkg::CODE_W;
    localparam int MAG_W  = fndp_pkg::MAG_W;
    localparam int VEC_W  = LANES * PROD_W;

    logic             r_valid, n_valid;
    logic [VEC_W-1:0] r_prods;
    logic             r_last;
    logic [VEC_W-1:0] w_prods;
    logic             w_take;

    // Each lane multiplies its activation by the decoded weight.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        localparam int BYTE_IDX = g % fndp_pkg::LANES_PER_WORD;
        logic signed [ACT_W-1:0]     w_act;
        logic        [CODE_W-1:0]    w_code;
        logic        [MAG_W-1:0]     w_mag;
        logic signed [ACT_W+MAG_W:0] w_mul;
        logic signed [PROD_W-1:0]    w_prod;

        if (g < fndp_pkg::LANES_PER_WORD) begin : g_low
            assign w_act = i_acts_low[BYTE_IDX*ACT_W +: ACT_W];
        end else begin : g_high
            assign w_act = i_acts_high[BYTE_IDX*ACT_W +: ACT_W];
        end

        assign w_code = i_weight_bytes[g*CODE_W +: CODE_W];
        assign w_mag  = fndp_pkg::e2m1_mag(w_code[CODE_W-2:0]);
        assign w_mul  = w_act * $signed({1'b0, w_mag});
        // The sign bit of the code negates the product; negative zero stays zero.
        assign w_prod = w_code[CODE_W-1] ? PROD_W'(-w_mul) : PROD_W'(w_mul);
        assign w_prods[g*PROD_W +: PROD_W] = w_prod;
    end

    // The stage holds one word; it drains into the queue whenever there is room.
    assign o_q_push = r_valid && !i_q_flags.full;
    assign o_full   = r_valid && i_q_flags.full;
    assign w_take   = i_push && !o_full;
    assign o_q_data = {r_last, r_prods};

    always_comb begin
        n_valid = w_take || (r_valid && i_q_flags.full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_prods <= w_prods;
            r_last  <= i_last_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fndp_back.sv =====
// Back part: reduces the lane products, accumulates and holds the finished sum.
`default_nettype none

module fndp_back #(
    parameter int LANES = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire fndp_pkg::t_q_flags             i_q_flags,
    input  wire logic [LANES*fndp_pkg::PROD_W:0] i_q_data,
    output logic                                o_q_pop,
    output logic                                o_empty,
    input  wire logic                           i_pop,
    output logic signed [fndp_pkg::OUT_W-1:0]   o_dot_sum
);

    localparam int PROD_W = fndp_pkg::PROD_W;
    localparam int OUT_W  = fndp_pkg::OUT_W;
    localparam int SUM_W  = PROD_W + $clog2(LANES);
    localparam int TREE_N = 1 << $clog2(LANES);

    logic signed [SUM_W-1:0] w_node [2*TREE_N-1];
    logic                    r_a_valid, n_a_valid;
    logic signed [SUM_W-1:0] r_a_sum;
    logic                    r_a_last;
    logic                    w_a_consume;
    logic                    w_a_ready;
    logic [OUT_W-1:0]        r_acc, n_acc;
    logic [OUT_W-1:0]        w_acc_sum;
    logic                    r_out_valid, n_out_valid;
    logic [OUT_W-1:0]        r_out;

    // Leaves of the adder tree: sign-extended products, unused leaves zero.
    for (genvar g = 0; g < TREE_N; g++) begin : g_leaf
        if (g < LANES) begin : g_used
            assign w_node[TREE_N-1+g] = {{(SUM_W-PROD_W){i_q_data[g*PROD_W+PROD_W-1]}},
                                         i_q_data[g*PROD_W +: PROD_W]};
        end else begin : g_pad
            assign w_node[TREE_N-1+g] = '0;
        end
    end

    // Inner nodes of the adder tree.
    for (genvar k = 0; k < TREE_N - 1; k++) begin : g_node
        assign w_node[k] = w_node[2*k+1] + w_node[2*k+2];
    end

    // The item-sum stage moves on unless a finished sum finds the output occupied.
    assign w_a_consume = r_a_valid && (!r_a_last || !r_out_valid || i_pop);
    assign w_a_ready   = !r_a_valid || w_a_consume;
    assign o_q_pop     = !i_q_flags.empty && w_a_ready;
    assign w_acc_sum   = r_acc + {{(OUT_W-SUM_W){r_a_sum[SUM_W-1]}}, r_a_sum};

    always_comb begin
        n_a_valid   = o_q_pop || (r_a_valid && !w_a_consume);
        n_acc       = r_acc;
        n_out_valid = r_out_valid && !i_pop;
        if (w_a_consume) begin
            if (r_a_last) begin
                n_acc       = '0;
                n_out_valid = 1'b1;
            end else begin
                n_acc = w_acc_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_a_valid   <= n_a_valid;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers of the item-sum stage and the output word.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a_sum  <= w_node[0];
            r_a_last <= i_q_data[LANES*PROD_W];
        end
        if (w_a_consume && r_a_last) begin
            r_out <= w_acc_sum;
        end
    end

    assign o_empty   = !r_out_valid;
    assign o_dot_sum = $signed(r_out);

endmodule

`default_nettype wire

// ===== rtl/fp4_nibble_int8_dot_product_core.sv =====
// Top level of the streaming FP4 weight by INT8 activation dot product.
//
// Usage: both sides look like a queue. A word of 16 activations, 16 packed
// E2M1 weights and a last flag is taken at a clock edge with i_push high and
// o_full low. Every word adds its 16 lane products into a 32-bit running sum
// that wraps. A word with the last flag set also produces one result word:
// the finished sum, shown on o_dot_sum while o_empty is low and taken at an
// edge with i_pop high. The running sum then restarts from zero.
// Throughput is one word per cycle while o_full stays low. With the result
// side draining, a last word's sum passes through the decode and multiply
// stage, the work queue and the adder tree stage feeding the accumulator,
// and then reaches the output register.
// When the receiver stalls, non-last words keep accumulating; a last word
// waits in the adder tree stage while the output register is occupied, the
// work queue (QUEUE_DEPTH words) fills behind it and o_full rises.
// Reset is synchronous and active low; it empties all stages and the queue
// and clears the running sum, ready on the first cycle after release.
`default_nettype none

module fp4_nibble_int8_dot_product_core #(
    parameter int LANES       = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_push,
    output logic                                     o_full,
    input  wire logic [fndp_pkg::ITEM_W-1:0]         i_acts_low,
    input  wire logic [fndp_pkg::ITEM_W-1:0]         i_acts_high,
    input  wire logic [fndp_pkg::ITEM_W-1:0]         i_weight_bytes,
    input  wire logic                                i_last_item,
    output logic                                     o_empty,
    input  wire logic                                i_pop,
    output logic signed [fndp_pkg::OUT_W-1:0]        o_dot_sum
);

    localparam int Q_W = LANES * fndp_pkg::PROD_W + 1;

    logic               w_q_push;
    logic               w_q_pop;
    logic [Q_W-1:0]     w_q_wdata;
    logic [Q_W-1:0]     w_q_rdata;
    fndp_pkg::t_q_flags w_q_flags;

    // Decode and multiply.
    fndp_front #(
        .LANES (LANES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_acts_low     (i_acts_low),
        .i_acts_high    (i_acts_high),
        .i_weight_bytes (i_weight_bytes),
        .i_last_item    (i_last_item),
        .o_q_push       (w_q_push),
        .i_q_flags      (w_q_flags),
        .o_q_data       (w_q_wdata)
    );

    // Work queue between the two parts.
    fndp_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .i_pop   (w_q_pop),
        .o_flags (w_q_flags),
        .o_data  (w_q_rdata)
    );

    // Reduce, accumulate and deliver.
    fndp_back #(
        .LANES (LANES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_flags (w_q_flags),
        .i_q_data  (w_q_rdata),
        .o_q_pop   (w_q_pop),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_dot_sum (o_dot_sum)
    );

endmodule

`default_nettype wire

// ===== rtl/fndp_checker.sv =====
// Port-level checker for the dot product core, bound to the top level.
`default_nettype none

module fndp_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_full,
    input wire logic                              o_empty,
    input wire logic                              i_pop,
    input wire logic signed [fndp_pkg::OUT_W-1:0] o_dot_sum
);

    // Reset leaves both sides idle on the next cycle.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("core not idle after reset");

    // A waiting result word holds until it is taken.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_dot_sum)))
        else $error("result word changed or vanished before pop");

    // Back-pressure on the input only arises from a stalled result.
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_full) |-> !o_empty)
        else $error("full raised with no result waiting");

endmodule

bind fp4_nibble_int8_dot_product_core fndp_checker u_fndp_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_full    (o_full),
    .o_empty   (o_empty),
    .i_pop     (i_pop),
    .o_dot_sum (o_dot_sum)
);

`default_nettype wire
